@@ hdl/scfp_pkg.sv @@
// shared types and constants for the serial command frame parser
`default_nettype none

package scfp_pkg;

  // frame phases
  localparam logic [2:0] PH_HDR1 = 3'd0;
  localparam logic [2:0] PH_HDR2 = 3'd1;
  localparam logic [2:0] PH_CMD  = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_CHK  = 3'd5;
  localparam logic [2:0] PH_TL1  = 3'd6;
  localparam logic [2:0] PH_TL2  = 3'd7;

  // event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_BYTE   = 2'd1;
  localparam logic [1:0] EV_ACCEPT = 2'd2;
  localparam logic [1:0] EV_DROP   = 2'd3;

  // drop reasons
  localparam logic [2:0] DR_NONE     = 3'd0;
  localparam logic [2:0] DR_BAD_HDR2 = 3'd1;
  localparam logic [2:0] DR_TOO_LONG = 3'd2;
  localparam logic [2:0] DR_CHECKSUM = 3'd3;
  localparam logic [2:0] DR_BAD_TL1  = 3'd4;
  localparam logic [2:0] DR_BAD_TL2  = 3'd5;

  // register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_HEADER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_HEADER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_TAIL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_TAIL   = 3'd4;

  // register reset values
  localparam logic [7:0] RST_MAX_PAYLOAD   = 8'd250;
  localparam logic [7:0] RST_FIRST_HEADER  = 8'hAA;
  localparam logic [7:0] RST_SECOND_HEADER = 8'h55;
  localparam logic [7:0] RST_FIRST_TAIL    = 8'h0D;
  localparam logic [7:0] RST_SECOND_TAIL   = 8'h0A;

  typedef struct packed {
    logic [7:0] max_payload;
    logic [7:0] first_header;
    logic [7:0] second_header;
    logic [7:0] first_tail;
    logic [7:0] second_tail;
  } cfg_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] command;
    logic [7:0] payload_length;
    logic [2:0] drop_reason;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/scfp_cfg_regs.sv @@
// configuration register file of the frame parser
`default_nettype none

module scfp_cfg_regs
  import scfp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  output cfg_t                      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAX_PAYLOAD:   cfg_nxt.max_payload   = cfg_data;
        REG_FIRST_HEADER:  cfg_nxt.first_header  = cfg_data;
        REG_SECOND_HEADER: cfg_nxt.second_header = cfg_data;
        REG_FIRST_TAIL:    cfg_nxt.first_tail    = cfg_data;
        REG_SECOND_TAIL:   cfg_nxt.second_tail   = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_payload   <= RST_MAX_PAYLOAD;
      cfg_r.first_header  <= RST_FIRST_HEADER;
      cfg_r.second_header <= RST_SECOND_HEADER;
      cfg_r.first_tail    <= RST_FIRST_TAIL;
      cfg_r.second_tail   <= RST_SECOND_TAIL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/scfp_core.sv @@
// frame state machine, running checksum and per-byte result
`default_nettype none

module scfp_core
  import scfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  input  wire cfg_t       cfg,
  output res_t            res,
  output logic            data_in_range
);

  logic [2:0] phase_r,   phase_nxt;
  logic [7:0] cmd_r,     cmd_nxt;
  logic [7:0] len_r,     len_nxt;
  logic [7:0] count_r,   count_nxt;
  logic [7:0] xor_r,     xor_nxt;
  logic [7:0] count_inc;

  assign count_inc = count_r + 8'd1;
  assign data_in_range = (phase_r != PH_DATA) || (count_r < len_r);

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    count_nxt = count_r;
    xor_nxt   = xor_r;
    res       = '0;
    unique case (phase_r)
      PH_HDR1: begin
        if (rx_byte == cfg.first_header) phase_nxt = PH_HDR2;
      end
      PH_HDR2: begin
        if (rx_byte == cfg.second_header) begin
          phase_nxt = PH_CMD;
        end else begin
          phase_nxt       = PH_HDR1;
          res.event_res   = EV_DROP;
          res.drop_reason = DR_BAD_HDR2;
        end
      end
      PH_CMD: begin
        cmd_nxt   = rx_byte;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt = rx_byte;
        if (rx_byte > cfg.max_payload) begin
          phase_nxt       = PH_HDR1;
          res.event_res   = EV_DROP;
          res.drop_reason = DR_TOO_LONG;
        end else begin
          count_nxt = 8'd0;
          xor_nxt   = cmd_r ^ rx_byte;
          phase_nxt = (rx_byte != 8'd0) ? PH_DATA : PH_CHK;
        end
      end
      PH_DATA: begin
        res.event_res     = EV_BYTE;
        res.payload_byte  = rx_byte;
        res.payload_index = count_r;
        xor_nxt           = xor_r ^ rx_byte;
        count_nxt         = count_inc;
        if (count_inc >= len_r) phase_nxt = PH_CHK;
      end
      PH_CHK: begin
        if (rx_byte == xor_r) begin
          phase_nxt = PH_TL1;
        end else begin
          phase_nxt       = PH_HDR1;
          res.event_res   = EV_DROP;
          res.drop_reason = DR_CHECKSUM;
        end
      end
      PH_TL1: begin
        if (rx_byte == cfg.first_tail) begin
          phase_nxt = PH_TL2;
        end else begin
          phase_nxt       = PH_HDR1;
          res.event_res   = EV_DROP;
          res.drop_reason = DR_BAD_TL1;
        end
      end
      PH_TL2: begin
        phase_nxt = PH_HDR1;
        if (rx_byte == cfg.second_tail) begin
          res.event_res      = EV_ACCEPT;
          res.command        = cmd_r;
          res.payload_length = len_r;
        end else begin
          res.event_res   = EV_DROP;
          res.drop_reason = DR_BAD_TL2;
        end
      end
      default: phase_nxt = PH_HDR1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR1;
      cmd_r   <= 8'd0;
      len_r   <= 8'd0;
      count_r <= 8'd0;
      xor_r   <= 8'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/serial_command_frame_parser.sv @@
// top level of the serial command frame parser
//
// in_ channel: one received serial byte per item (in_rx_byte), valid/stall.
// out_ channel: exactly one result item per input item, in order: event
//   (none, payload byte, frame accepted, frame dropped) with payload byte and
//   index, command and length, or drop reason; unused fields read zero.
// cfg_ channel: valid/ready write of max_payload, header and tail bytes by
//   index 0..4; higher indexes are ignored. cfg_ready is always high.
// path: an item taken lands in the input register; its result is written to
//   the result register, which drives out_valid, once the output is free.
// throughput: one item per cycle while the output is not stalled; the frame
//   state update is a single compare/xor step between the input register
//   and the result register.
// stall: when out_stall holds a result, the input register fills and then
//   in_stall is raised; nothing is lost or repeated.
// reset: synchronous rst_n empties both registers, returns the parser to
//   hunting for the first header and reloads the register defaults.
`default_nettype none

module serial_command_frame_parser
  import scfp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_event_res,
  output logic [7:0]                out_payload_byte,
  output logic [7:0]                out_payload_index,
  output logic [7:0]                out_command,
  output logic [7:0]                out_payload_length,
  output logic [2:0]                out_drop_reason,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  cfg_t       cfg;
  res_t       res;
  res_t       res_r;
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       out_vld_r;
  logic       out_free;
  logic       step;
  logic       in_take;
  logic       data_in_range;

  scfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  scfp_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .rx_byte       (in_byte_r),
    .cfg           (cfg),
    .res           (res),
    .data_in_range (data_in_range)
  );

  assign out_free = !out_vld_r || !out_stall;
  assign step     = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (step) begin
        in_vld_r <= 1'b0;
      end
      if (step) begin
        out_vld_r <= 1'b1;
      end else if (out_free) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_byte_r <= in_rx_byte;
    if (step) res_r <= res;
  end

  assign out_valid          = out_vld_r;
  assign out_event_res      = res_r.event_res;
  assign out_payload_byte   = res_r.payload_byte;
  assign out_payload_index  = res_r.payload_index;
  assign out_command        = res_r.command;
  assign out_payload_length = res_r.payload_length;
  assign out_drop_reason    = res_r.drop_reason;

  // stall only ever raised while the input register holds an item
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_vld_r && out_stall))
    else $error("input stalled with an empty input register");

  // payload byte counter never runs past the frame length
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    data_in_range)
    else $error("payload count reached frame length while still in payload");

  // a drop carries a reason, nothing else does
  a_drop_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ((res_r.event_res == EV_DROP) == (res_r.drop_reason != DR_NONE)))
    else $error("drop reason does not match event");

  // a result is registered exactly when an item leaves the input register
  a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_vld_r)
    else $error("result lost after a step");

endmodule

`default_nettype wire
